FILE: design/linear_probe_hash_table_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the linear probe hash table
// Shorthand for clocked assertions that are disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht assertion failed");

`endif

FILE: design/lpht_pkg.sv
// ---------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, command codes and sequencer states.
// ---------------------------------------------------------------------------
package lpht_pkg;

  localparam int SIZE_W = 9;
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 32;
  localparam int HASH_W = 32;
  localparam int DATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

FILE: design/lpht_if.sv
// ---------------------------------------------------------------------------
// Linear probe hash table channel interfaces
// Valid/ready channels for commands, results and the size register.
// ---------------------------------------------------------------------------
interface lpht_in_if;
  import lpht_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key;
  logic [HASH_W-1:0] hash_value;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, cmd, key, hash_value, data_in, input ready);
  modport sink (input valid, cmd, key, hash_value, data_in, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [DATA_W-1:0] data_out;
  logic [SIZE_W-1:0] entry_count;

  modport source (output valid, ok, data_out, entry_count, input ready);
  modport sink (input valid, ok, data_out, entry_count, output ready);
endinterface

interface lpht_cfg_if;
  import lpht_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;

  modport source (output valid, table_size, input ready);
  modport sink (input valid, table_size, output ready);
endinterface

FILE: design/linear_probe_hash_table_top.sv
// A command runs a bit-serial modulo of its hash by the table size, then probes the slots one
// by one through the single read port of the slot memory, then writes back; an unused command
// code skips both and goes straight to the result. A command waits for the result register
// while an earlier result is still held at the output. A new transaction is taken once the
// result registers. After reset and every table_size write, a clearing sweep writes every
// slot of the memory, and no input is taken meanwhile.
// ---------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing key/data table with linear probing, driven by a small
// sequencer around a bit-serial divider and a slot memory with a read and a write port.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_top #(
  parameter int SLOTS     = 256,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  lpht_cfg_if.sink   cfg_ch,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch
);
  import lpht_pkg::*;

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int DW      = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
  localparam int ENTRY_W = 1 + KW + DW;
  localparam int STEP_W  = $clog2(HASH_W);
  localparam int CMP_W   = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return SIZE_W'(1);
    end
    if (32'(v) > 32'(SLOTS)) begin
      return SIZE_W'(SLOTS);
    end
    return v;
  endfunction

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [SIZE_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                out_vld_r, out_vld_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [DW-1:0]       data_r, data_nxt;
  logic [SIZE_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SIZE_W-1:0]   issued_r, issued_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic                found_used_r, found_used_nxt;
  logic [DW-1:0]       found_data_r, found_data_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [SIZE_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic [ENTRY_W-1:0]  mem [SLOTS];
  logic [ENTRY_W-1:0]  rd_q_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;

  logic                rd_used;
  logic [KW-1:0]       rd_key;
  logic [DW-1:0]       rd_data;
  logic                probe_stop;
  logic                probe_iss;
  logic [SIZE_W:0]     trial;
  logic [SIZE_W:0]     diff;
  logic                out_free;
  logic                cfg_acc;
  logic                in_acc;

  assign rd_used = rd_q_r[ENTRY_W-1];
  assign rd_key  = rd_q_r[DW +: KW];
  assign rd_data = rd_q_r[DW-1:0];

  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_vld_r || out_ch.ready;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.entry_count = out_cnt_r;

  assign trial = {rem_r, hash_r[HASH_W-1]};
  assign diff  = trial - {1'b0, size_r};

  assign probe_stop = rd_vld_r && (!rd_used || (rd_key == key_r));
  assign probe_iss  = (issued_r != size_r) && !probe_stop;

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    rd_vld_nxt     = 1'b0;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    hash_nxt       = hash_r;
    data_nxt       = data_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    idx_nxt        = idx_r;
    issued_nxt     = issued_r;
    rd_idx_nxt     = rd_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    found_used_nxt = found_used_r;
    found_data_nxt = found_data_r;
    out_ok_nxt     = out_ok_r;
    out_data_nxt   = out_data_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = hit_idx_r;
    mem_wdata      = '0;
    mem_raddr      = idx_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (cfg_acc) begin
          size_nxt  = clamp_size(cfg_ch.table_size);
          count_nxt = '0;
          clr_nxt   = '0;
          state_nxt = ST_CLEAR;
        end else if (in_acc) begin
          cmd_nxt  = in_ch.cmd;
          key_nxt  = in_ch.key[KW-1:0];
          hash_nxt = in_ch.hash_value;
          data_nxt = in_ch.data_in[DW-1:0];
          rem_nxt  = '0;
          step_nxt = '0;
          hit_nxt  = 1'b0;
          case (in_ch.cmd)
            CMD_INSERT, CMD_REMOVE, CMD_GET: state_nxt = ST_DIV;
            default:                         state_nxt = ST_DONE;
          endcase
        end
      end

      ST_DIV: begin
        if (diff[SIZE_W] == 1'b0) begin
          rem_nxt = diff[SIZE_W-1:0];
        end else begin
          rem_nxt = trial[SIZE_W-1:0];
        end
        hash_nxt = hash_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(HASH_W - 1)) begin
          idx_nxt    = IDX_W'(rem_nxt);
          issued_nxt = '0;
          state_nxt  = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (probe_iss) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          issued_nxt = issued_r + SIZE_W'(1);
          if (CMP_W'(idx_r) == CMP_W'(size_r) - CMP_W'(1)) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        if (probe_stop) begin
          hit_nxt        = 1'b1;
          hit_idx_nxt    = rd_idx_r;
          found_used_nxt = rd_used;
          found_data_nxt = rd_data;
          state_nxt      = ST_DONE;
        end else if (rd_vld_r && (issued_r == size_r)) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_ok_nxt   = 1'b0;
          out_data_nxt = '0;
          case (cmd_r)
            CMD_INSERT: begin
              if (hit_r && !found_used_r) begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b1, key_r, data_r};
                count_nxt  = count_r + SIZE_W'(1);
                out_ok_nxt = 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (hit_r && found_used_r) begin
                mem_we       = 1'b1;
                count_nxt    = count_r - SIZE_W'(1);
                out_ok_nxt   = 1'b1;
                out_data_nxt = DATA_W'(found_data_r);
              end
            end
            CMD_GET: begin
              if (hit_r && found_used_r) begin
                out_ok_nxt   = 1'b1;
                out_data_nxt = DATA_W'(found_data_r);
              end
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
          out_cnt_nxt = count_nxt;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      size_r    <= clamp_size(SIZE_RESET);
      count_r   <= '0;
      clr_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      size_r    <= size_nxt;
      count_r   <= count_nxt;
      clr_r     <= clr_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    hash_r       <= hash_nxt;
    data_r       <= data_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    idx_r        <= idx_nxt;
    issued_r     <= issued_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    found_used_r <= found_used_nxt;
    found_data_r <= found_data_nxt;
    out_ok_r     <= out_ok_nxt;
    out_data_r   <= out_data_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[mem_raddr];
  end

endmodule

FILE: design/lpht_checker.sv
// ---------------------------------------------------------------------------
// Linear probe hash table port checker
// Watches the top-level channels for ordering and result consistency.
// ---------------------------------------------------------------------------
`include "linear_probe_hash_table_top_macros.svh"

module lpht_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_ok,
  input logic [lpht_pkg::DATA_W-1:0] out_data_out,
  input logic [lpht_pkg::SIZE_W-1:0] out_entry_count,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);
  import lpht_pkg::*;

  // A stalled result keeps its contents.
  `LPHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ok) && $stable(out_data_out) && $stable(out_entry_count))

  // Only one command is in flight at a time.
  `LPHT_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready)

  // A size write starts the clearing sweep, which blocks both inputs.
  `LPHT_ASSERT_NEXT(a_cfg_clear, cfg_valid && cfg_ready, !in_ready && !cfg_ready)

  // A failed command returns zero data.
  `LPHT_ASSERT_SAME(a_fail_zero, out_valid && !out_ok, out_data_out == '0)

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ok          (out_ch.ok),
  .out_data_out    (out_ch.data_out),
  .out_entry_count (out_ch.entry_count),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready)
);

FILE: tb/linear_probe_hash_table_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Linear probe hash table testbench
// Sends insert, remove and get commands through the valid/ready command
// channel, predicts every result with a behavioral copy of the slot table,
// and checks each result transaction field by field. Directed tests cover
// key and data extremes, wrap-around, duplicates, full tables and cut probe
// chains; random phases run at many table sizes with bursty traffic and a
// stalling result sink.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_top_tb;
  import lpht_pkg::*;

  localparam int              TB_SLOTS    = 256;
  localparam int              CYCLE_LIMIT = 1_500_000;
  localparam int              DRAIN_WAIT  = 40;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] count;
  } lookup_result_t;

  logic clk;
  logic rst_n;

  lpht_cfg_if cfg_if ();
  lpht_in_if  in_if ();
  lpht_out_if out_if ();

  linear_probe_hash_table_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_if),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  bit                slot_taken [TB_SLOTS];
  logic [KEY_W-1:0]  slot_keys  [TB_SLOTS];
  logic [DATA_W-1:0] slot_vals  [TB_SLOTS];
  int unsigned       live_size;
  int unsigned       live_count;

  lookup_result_t pending_results [$];

  int  error_count;
  int  commands_sent;
  int  results_checked;
  int  hits_predicted;
  int  size_writes;
  int  cycle_count;
  int  burst_left;
  bit  cmd_valid_high;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got %h, expected %h",
             results_checked, what, got, want);
    error_count++;
  endtask

  function automatic void table_resize(input logic [SIZE_W-1:0] value);
    if (value == 0) live_size = 1;
    else if (value > TB_SLOTS) live_size = TB_SLOTS;
    else live_size = 32'(value);
    for (int i = 0; i < TB_SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      slot_keys[i]  = '0;
      slot_vals[i]  = '0;
    end
    live_count = 0;
  endfunction

  function automatic lookup_result_t table_apply(input logic [CMD_W-1:0] cmd,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [HASH_W-1:0] hash,
                                                 input logic [DATA_W-1:0] data);
    lookup_result_t r;
    int unsigned    idx;
    int             stop;
    r    = '0;
    stop = -1;
    if (cmd != CMD_UNUSED) begin
      idx = hash % live_size;
      for (int unsigned i = 0; i < live_size && stop < 0; i++) begin
        if (!slot_taken[idx] || slot_keys[idx] == key) stop = idx;
        else idx = (idx + 1 == live_size) ? 0 : idx + 1;
      end
      if (stop >= 0) begin
        if (cmd == CMD_INSERT) begin
          if (!slot_taken[stop]) begin
            slot_taken[stop] = 1'b1;
            slot_keys[stop]  = key;
            slot_vals[stop]  = data;
            live_count++;
            r.ok = 1'b1;
          end
        end else if (slot_taken[stop]) begin
          r.data = slot_vals[stop];
          r.ok   = 1'b1;
          if (cmd == CMD_REMOVE) begin
            slot_taken[stop] = 1'b0;
            slot_keys[stop]  = '0;
            slot_vals[stop]  = '0;
            if (live_count > 0) live_count--;
          end
        end
      end
    end
    r.count = live_count[SIZE_W-1:0];
    return r;
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [HASH_W-1:0] hash,
                              input logic [DATA_W-1:0] data);
    int roll;
    if (burst_left == 0) begin
      if (cmd_valid_high) begin
        in_if.valid <= 1'b0;
        cmd_valid_high = 1'b0;
      end
      roll = $urandom_range(0, 9);
      if (roll < 5) repeat ($urandom_range(1, 6)) @(posedge clk);
      else if (roll < 8) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(35, 120)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.key        <= key;
    in_if.hash_value <= hash;
    in_if.data_in    <= data;
    cmd_valid_high = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(table_apply(cmd, key, hash, data));
    if (pending_results[$].ok) hits_predicted++;
    commands_sent++;
    burst_left--;
  endtask

  task automatic wait_idle();
    if (cmd_valid_high) begin
      in_if.valid <= 1'b0;
      cmd_valid_high = 1'b0;
    end
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    wait_idle();
    cfg_if.valid      <= 1'b1;
    cfg_if.table_size <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    table_resize(value);
    size_writes++;
  endtask

  // The result sink stalls on a rotating 16-bit pattern, reloaded after each
  // full pass; bit 15 is forced high so that no stall is endless.
  initial begin : result_sink
    logic [15:0] stall_pat;
    int          phase;
    out_if.ready <= 1'b0;
    stall_pat = 16'hFFFF;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (phase == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hFFFF;
          1:       stall_pat = 16'($urandom);
          2:       stall_pat = 16'($urandom & $urandom);
          default: stall_pat = 16'($urandom | $urandom);
        endcase
        stall_pat[15] = 1'b1;
      end
      out_if.ready <= stall_pat[phase];
      phase = (phase + 1) % 16;
    end
  end

  always @(posedge clk) begin : result_check
    lookup_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command outstanding", out_if.data_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.ok !== want.ok) report_mismatch("ok", 32'(out_if.ok), 32'(want.ok));
        if (out_if.data_out !== want.data)
          report_mismatch("data_out", out_if.data_out, want.data);
        if (out_if.entry_count !== want.count)
          report_mismatch("entry_count", 32'(out_if.entry_count), 32'(want.count));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_basic_commands();
    send_command(CMD_GET, 32'h0000_1234, 32'h0, 32'h1111_1111);
    send_command(CMD_REMOVE, 32'h0000_1234, 32'h0, 32'h2222_2222);
    send_command(CMD_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_command(CMD_INSERT, 32'h0, 32'h0, 32'h0000_0005);
    send_command(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
    send_command(CMD_UNUSED, 32'h0, 32'h0, 32'h5555_5555);
    send_command(CMD_REMOVE, 32'h0, 32'h0, 32'h0);
    send_command(CMD_GET, 32'h0, 32'h0, 32'h0);
    send_command(CMD_INSERT, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_command(CMD_GET, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_size_extremes();
    write_table_size(9'd0);
    send_command(CMD_INSERT, 32'hCAFE_0001, 32'h1234_5678, 32'h0BAD_F00D);
    send_command(CMD_INSERT, 32'hCAFE_0002, 32'h1234_5678, 32'h1357_9BDF);
    send_command(CMD_GET, 32'hCAFE_0002, 32'h8765_4321, 32'h0);
    send_command(CMD_GET, 32'hCAFE_0001, 32'hDEAD_BEEF, 32'h0);
    write_table_size(9'd511);
    send_command(CMD_GET, 32'hCAFE_0001, 32'h1234_5678, 32'h0);
  endtask

  task automatic test_chain_cut();
    write_table_size(9'd4);
    send_command(CMD_INSERT, 32'h0000_0A01, 32'h1, 32'h1000_0001);
    send_command(CMD_INSERT, 32'h0000_0A02, 32'h1, 32'h2000_0002);
    send_command(CMD_INSERT, 32'h0000_0A03, 32'h1, 32'h3000_0003);
    send_command(CMD_INSERT, 32'h0000_0A04, 32'h1, 32'h4000_0004);
    send_command(CMD_INSERT, 32'h0000_0A05, 32'h1, 32'h5000_0005);
    send_command(CMD_REMOVE, 32'h0000_0A02, 32'h1, 32'h0);
    send_command(CMD_GET, 32'h0000_0A03, 32'h1, 32'h0);
    send_command(CMD_GET, 32'h0000_0A04, 32'h1, 32'h0);
    send_command(CMD_INSERT, 32'h0000_0A03, 32'h1, 32'h3300_0033);
  endtask

  // Most commands use a small key pool whose size tracks the table size, so
  // tables fill, collide and wrap; the rest are unrelated noise commands.
  task automatic test_random_traffic();
    logic [SIZE_W-1:0] phase_sizes [12] = '{9'd2, 9'd1, 9'd7, 9'd300, 9'd16, 9'd3,
                                            9'd64, 9'd5, 9'd256, 9'd11, 9'd0, 9'd0};
    logic [KEY_W-1:0]  pool_key  [48];
    logic [HASH_W-1:0] pool_hash [48];
    logic [SIZE_W-1:0] size_val;
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    int                pool_n;
    int                pick;
    int                roll;
    for (int ph = 0; ph < 12; ph++) begin
      size_val = (ph == 10) ? 9'($urandom_range(1, 32)) : phase_sizes[ph];
      write_table_size(size_val);
      pool_n = live_size + live_size / 2 + 2;
      if (pool_n > 48) pool_n = 48;
      for (int i = 0; i < pool_n; i++) begin
        pool_key[i]  = $urandom;
        pool_hash[i] = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
      end
      for (int n = 0; n < 75; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          pick = $urandom_range(0, pool_n - 1);
          key  = pool_key[pick];
          hash = ($urandom_range(0, 19) == 0) ? $urandom : pool_hash[pick];
          roll = $urandom_range(0, 99);
          if (roll < 42) cmd = CMD_INSERT;
          else if (roll < 72) cmd = CMD_GET;
          else if (roll < 97) cmd = CMD_REMOVE;
          else cmd = CMD_UNUSED;
        end else begin
          key  = $urandom;
          hash = $urandom;
          cmd  = CMD_W'($urandom_range(0, 3));
        end
        send_command(cmd, key, hash, $urandom);
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.cmd         <= CMD_INSERT;
    in_if.key         <= '0;
    in_if.hash_value  <= '0;
    in_if.data_in     <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.table_size <= '0;
    table_resize(SIZE_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_size_extremes();
    test_chain_cut();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_results.size()), '0);
    $display("Checked %0d results from %0d commands, %0d of them successful.",
             results_checked, commands_sent, hits_predicted);
    $display("Table size was written %0d times, from one slot up to the full table.",
             size_writes);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
